// File: hw/rtl/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg: shared types and constants for the linear-probe hash set
// Holds table geometry, status codes, controller states and the command and
// status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

    // Table geometry (SLOT_COUNT must be a power of two, 16 .. 1048576)
    localparam int SLOT_COUNT = 4096;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int KEY_W      = 64;
    localparam int HOME_LSB   = 3;

    // Field widths of the ports
    localparam int COUNT_W = 13;
    localparam int STAT_W  = 3;

    // Internal count must hold SLOT_COUNT itself
    localparam int CNT_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;

    localparam logic [COUNT_W-1:0] FILL_LIMIT_RESET = COUNT_W'(1875);

    // Request command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_NEW     = 3'd0,
        STAT_PRESENT = 3'd1,
        STAT_LIMIT   = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_ZERO    = 3'd4,
        STAT_CLEARED = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_CHECK,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    load_home;
        logic    idx_inc;
        logic    probe_clr;
        logic    probe_inc;
        logic    mem_rd;
        logic    mem_wr_key;
        logic    mem_wr_zero;
        logic    cnt_inc;
        logic    cnt_clr;
        logic    set_status;
        status_t status;
        logic    out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic key_zero;
        logic at_limit;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lphs_dp.sv
// ----------------------------------------------------------------------------
// lphs_dp: datapath of the linear-probe hash set
// Slot memory, probe index and counter, stored count, fill limit register
// and the result register that faces the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire lphs_pkg::dp_cmd_t              cmd,
    output lphs_pkg::dp_stat_t                  stat,
    input  wire logic                           s_command,
    input  wire logic [lphs_pkg::KEY_W-1:0]     s_key,
    input  wire logic                           fill_limit_we,
    input  wire logic [lphs_pkg::COUNT_W-1:0]   fill_limit_wdata,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [lphs_pkg::STAT_W-1:0]         m_status,
    output logic [lphs_pkg::COUNT_W-1:0]        m_stored_total
);
    import lphs_pkg::*;

    logic [KEY_W-1:0]   slot_mem [SLOT_COUNT];
    logic [KEY_W-1:0]   rdata_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               command_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [IDX_W-1:0]   probe_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0] fill_limit_reg;
    status_t            status_reg;
    logic               m_valid_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic [COUNT_W-1:0] m_total_reg;
    logic               out_free;

    // Latch the accepted request
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            command_reg <= s_command;
            key_reg     <= s_key;
        end
    end

    // Probe and sweep address; reset starts the clearing sweep at slot zero
    always_comb begin
        idx_next = idx_reg;
        if (cmd.load_home) begin
            idx_next = key_reg[HOME_LSB +: IDX_W];
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    // Count probes taken for the table-full guard
    always_ff @(posedge aclk) begin
        if (cmd.probe_clr) begin
            probe_reg <= '0;
        end else if (cmd.probe_inc) begin
            probe_reg <= probe_reg + IDX_W'(1);
        end
    end

    // Slot memory: one port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr_key) begin
            slot_mem[idx_reg] <= key_reg;
        end else if (cmd.mem_wr_zero) begin
            slot_mem[idx_reg] <= '0;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= slot_mem[idx_reg];
        end
    end

    // Stored count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_clr) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Fill limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_limit_reg <= FILL_LIMIT_RESET;
        end else if (fill_limit_we) begin
            fill_limit_reg <= fill_limit_wdata;
        end
    end

    // Hold the outcome of the current request
    always_ff @(posedge aclk) begin
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
    end

    // Result register toward the output channel
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= status_reg;
            m_total_reg  <= count_reg[COUNT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_stored_total = m_total_reg;

    // Status back to the controller
    always_comb begin
        stat.is_clear   = (command_reg == CMD_CLEAR);
        stat.key_zero   = (key_reg == '0);
        stat.at_limit   = (count_reg >= CNT_W'(fill_limit_reg));
        stat.slot_empty = (rdata_reg == '0);
        stat.slot_match = (rdata_reg == key_reg);
        stat.probe_last = &probe_reg;
        stat.idx_last   = &idx_reg;
        stat.out_free   = out_free;
    end

    // A new key only lands in a slot that was read back empty
    a_write_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr_key |-> (rdata_reg == '0))
        else $error("key written over an occupied slot");

    // The count never passes the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOT_COUNT))
        else $error("stored count above table size");

    // A result is never loaded over one that is still waiting
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result overwritten before it was taken");

    // Each insert raises the count by exactly one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("count did not step by one");

endmodule

`default_nettype wire

// File: hw/rtl/lphs_ctrl.sv
// ----------------------------------------------------------------------------
// lphs_ctrl: controller of the linear-probe hash set
// Sequences the reset sweep, the decision on each request, the probe loop,
// the clear sweep and the hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lphs_pkg::dp_stat_t stat,
    output lphs_pkg::dp_cmd_t       cmd
);
    import lphs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_NEW;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                // sweep zeros through every slot after reset
                cmd.mem_wr_zero = 1'b1;
                cmd.idx_inc     = 1'b1;
                if (stat.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.probe_clr = 1'b1;
                if (stat.is_clear) begin
                    state_next = ST_CLEAR;
                end else if (stat.key_zero) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_ZERO;
                    state_next     = ST_DONE;
                end else if (stat.at_limit) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_LIMIT;
                    state_next     = ST_DONE;
                end else begin
                    cmd.load_home = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.set_status = 1'b1;
                if (stat.slot_empty) begin
                    cmd.mem_wr_key = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.status     = STAT_NEW;
                    state_next     = ST_DONE;
                end else if (stat.slot_match) begin
                    cmd.status = STAT_PRESENT;
                    state_next = ST_DONE;
                end else if (stat.probe_last) begin
                    cmd.status = STAT_FULL;
                    state_next = ST_DONE;
                end else begin
                    // advance to the next slot with wrap
                    cmd.set_status = 1'b0;
                    cmd.idx_inc    = 1'b1;
                    cmd.probe_inc  = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_CLEAR: begin
                // zero every slot once, wrapping from wherever the index stands;
                // the probe counter marks the last slot of the sweep
                cmd.mem_wr_zero = 1'b1;
                cmd.idx_inc     = 1'b1;
                cmd.probe_inc   = 1'b1;
                if (stat.probe_last) begin
                    cmd.cnt_clr    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_CLEARED;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // A request is only taken when no earlier one is in flight
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECIDE))
        else $error("accepted request did not move to decide");

    // Memory writes and reads never share a cycle
    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_rd |-> !(cmd.mem_wr_key || cmd.mem_wr_zero))
        else $error("read and write on the slot port together");

    // Every probe read is followed by its check
    a_read_check: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_rd |=> (state_reg == ST_CHECK))
        else $error("probe read without check");

endmodule

`default_nettype wire

// File: hw/rtl/linear_probe_hash_set_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set_top: open-addressed visited set, linear probing
// Inserts 64-bit keys into a slot table, reports new, present, limit,
// full, zero key or cleared together with the stored count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_command, s_key
//  m_        out        m_valid/m_ready    m_status, m_stored_total
//  config    in         fill_limit_we      fill_limit_wdata
//
//  Insert: decide, then a read and a check per slot probed (one registered
//  read and one compare on the single memory port), then done; zero key or
//  limit go from decide straight to done. Clear: one slot zeroed per cycle.
//  After reset a clearing pass over every slot runs before s_ready rises.
//  A waiting result does not stop the next request; it stalls only at hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_command,
    input  wire logic [lphs_pkg::KEY_W-1:0]     s_key,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [lphs_pkg::STAT_W-1:0]         m_status,
    output logic [lphs_pkg::COUNT_W-1:0]        m_stored_total,
    input  wire logic                           fill_limit_we,
    input  wire logic [lphs_pkg::COUNT_W-1:0]   fill_limit_wdata
);
    import lphs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lphs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lphs_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_command        (s_command),
        .s_key            (s_key),
        .fill_limit_we    (fill_limit_we),
        .fill_limit_wdata (fill_limit_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_stored_total   (m_stored_total)
    );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the linear-probe hash set
// Streams insert and clear requests through the valid/ready input channel,
// mirrors the slot table in a local model to predict status and stored total,
// and compares every result in order. The fill limit is rewritten between
// phases, including one phase of collisions that wrap past the table end,
// under three idling patterns on the two channels.
// ----------------------------------------------------------------------------

module tb_top;

    import lphs_pkg::*;

    // Worst case is far below this: clears that each sweep every slot,
    // long probes through clustered homes, all with heavy output stalls
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SEG_ITEMS   = 105;

    typedef enum logic [1:0] {
        PLAN_REQUEST,
        PLAN_LIMIT,
        PLAN_DRAIN,
        PLAN_PACE
    } plan_kind_t;

    typedef struct {
        plan_kind_t       kind;
        logic             command;
        logic [KEY_W-1:0] key;
        int               limit;
        int               send_pct;
        int               recv_pct;
    } plan_step_t;

    typedef struct {
        status_t            status;
        logic [COUNT_W-1:0] total;
    } outcome_t;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic                 s_command        = CMD_INSERT;
    logic [KEY_W-1:0]     s_key            = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [STAT_W-1:0]    m_status;
    logic [COUNT_W-1:0]   m_stored_total;
    logic                 fill_limit_we    = 1'b0;
    logic [COUNT_W-1:0]   fill_limit_wdata = '0;

    plan_step_t       request_plan[$];
    outcome_t         outcome_q[$];
    logic [KEY_W-1:0] seen_keys[$];

    // Mirror of the block state
    logic [KEY_W-1:0] slot_mirror[SLOT_COUNT];
    int               key_count = 0;
    int               limit_reg = int'(FILL_LIMIT_RESET);

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic req_taken     = 1'b0;
    int   cycle_count   = 0;
    int   error_count   = 0;

    linear_probe_hash_set_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_key            (s_key),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_stored_total   (m_stored_total),
        .fill_limit_we    (fill_limit_we),
        .fill_limit_wdata (fill_limit_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the mirrored set and return what the block reports
    function automatic outcome_t probe_and_record(logic cmd, logic [KEY_W-1:0] k);
        outcome_t o;
        int       slot;
        int       n;
        logic     found;
        o.status = STAT_FULL;
        found    = 1'b0;
        if (cmd == CMD_CLEAR) begin
            foreach (slot_mirror[i]) slot_mirror[i] = '0;
            key_count = 0;
            o.status  = STAT_CLEARED;
        end else if (k == '0) begin
            o.status = STAT_ZERO;
        end else if (key_count >= limit_reg) begin
            o.status = STAT_LIMIT;
        end else begin
            slot = int'(k[HOME_LSB +: IDX_W]);
            for (n = 0; n < SLOT_COUNT && !found; n++) begin
                if (slot_mirror[slot] == '0) begin
                    slot_mirror[slot] = k;
                    key_count++;
                    o.status = STAT_NEW;
                    found    = 1'b1;
                end else if (slot_mirror[slot] == k) begin
                    o.status = STAT_PRESENT;
                    found    = 1'b1;
                end else begin
                    slot = (slot + 1) % SLOT_COUNT;
                end
            end
        end
        o.total = COUNT_W'(key_count);
        return o;
    endfunction

    task automatic push_request(logic cmd, logic [KEY_W-1:0] k);
        plan_step_t p;
        p.kind = PLAN_REQUEST; p.command = cmd; p.key = k;
        p.limit = 0; p.send_pct = 0; p.recv_pct = 0;
        request_plan.push_back(p);
    endtask

    task automatic push_limit(int value);
        plan_step_t p;
        p.kind = PLAN_LIMIT; p.command = CMD_INSERT; p.key = '0;
        p.limit = value; p.send_pct = 0; p.recv_pct = 0;
        request_plan.push_back(p);
    endtask

    task automatic push_drain();
        plan_step_t p;
        p.kind = PLAN_DRAIN; p.command = CMD_INSERT; p.key = '0;
        p.limit = 0; p.send_pct = 0; p.recv_pct = 0;
        request_plan.push_back(p);
    endtask

    task automatic push_pace(int sp, int rp);
        plan_step_t p;
        p.kind = PLAN_PACE; p.command = CMD_INSERT; p.key = '0;
        p.limit = 0; p.send_pct = sp; p.recv_pct = rp;
        request_plan.push_back(p);
    endtask

    // One random segment: new limit, then a mix of repeats, clustered homes,
    // wide random keys, zero keys and rare clears
    task automatic push_segment(int limit, int hot_base);
        logic [KEY_W-1:0] k;
        int               r;
        int               j;
        push_limit(limit);
        for (j = 0; j < SEG_ITEMS; j++) begin
            r = $urandom_range(999);
            k = {$urandom, $urandom};
            if (r < 8) begin
                push_request(CMD_CLEAR, k);
            end else begin
                if (r < 30) begin
                    k = '0;
                end else if (r < 330 && seen_keys.size() > 0) begin
                    k = seen_keys[$urandom_range(seen_keys.size() - 1)];
                end else if (r < 650) begin
                    k[HOME_LSB +: IDX_W] = IDX_W'((hot_base + $urandom_range(7)) % SLOT_COUNT);
                    if (k == '0) k[KEY_W-1] = 1'b1;
                end
                if (k != '0) begin
                    seen_keys.push_back(k);
                    if (seen_keys.size() > 96) void'(seen_keys.pop_front());
                end
                push_request(CMD_INSERT, k);
            end
        end
    endtask

    // Driver: present planned requests, write the limit only when idle
    always @(negedge aclk) begin : drive_requests
        plan_step_t head;
        logic       valid_nxt;
        logic       we_nxt;
        valid_nxt = s_valid;
        we_nxt    = 1'b0;
        if (aresetn && !(s_valid && !req_taken)) begin
            valid_nxt = 1'b0;
            if (request_plan.size() > 0) begin
                head = request_plan[0];
                case (head.kind)
                    PLAN_REQUEST: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            void'(request_plan.pop_front());
                            valid_nxt = 1'b1;
                            s_command <= head.command;
                            s_key     <= head.key;
                        end
                    end
                    PLAN_LIMIT: begin
                        if (outcome_q.size() == 0) begin
                            void'(request_plan.pop_front());
                            we_nxt = 1'b1;
                            fill_limit_wdata <= COUNT_W'(head.limit);
                        end
                    end
                    PLAN_DRAIN: begin
                        if (outcome_q.size() == 0) void'(request_plan.pop_front());
                    end
                    default: begin
                        void'(request_plan.pop_front());
                        send_idle_pct = head.send_pct;
                        recv_idle_pct = head.recv_pct;
                    end
                endcase
            end
        end
        s_valid       <= valid_nxt;
        fill_limit_we <= we_nxt;
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge aclk) begin : check_results
        outcome_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, outcome_q.size());
            $display("tb_top: done, errors");
            $finish;
        end else if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (fill_limit_we) limit_reg = int'(fill_limit_wdata);
            if (s_valid && s_ready) outcome_q.push_back(probe_and_record(s_command, s_key));
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected: status %0d total %0d",
                             $time, m_status, m_stored_total);
                end else begin
                    want = outcome_q.pop_front();
                    if (m_status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                    end
                    if (m_stored_total !== want.total) begin
                        error_count++;
                        $display("%0t: stored_total expected %0d actual %0d",
                                 $time, want.total, m_stored_total);
                    end
                end
            end
        end
    end

    initial begin : run_plan
        foreach (slot_mirror[i]) slot_mirror[i] = '0;

        // Phase one pacing: sender idles often, receiver mostly stalled
        push_pace(37, 84);

        // Directed: zero key, extremes, collisions, wrap at the table end
        push_request(CMD_INSERT, 64'h0);
        push_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        push_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        push_request(CMD_INSERT, 64'h1);
        push_request(CMD_INSERT, 64'h8000_0000_0000_0000);
        push_request(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFF8);
        push_request(CMD_INSERT, 64'h9);
        push_request(CMD_INSERT, 64'h8000_0000_0000_0000);
        push_request(CMD_CLEAR,  64'hA5A5_5A5A_0F0F_F0F0);
        push_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        push_request(CMD_CLEAR,  64'h0);
        // Limit of zero refuses every nonzero insert, zero key still wins
        push_limit(0);
        push_request(CMD_INSERT, 64'h5);
        push_request(CMD_INSERT, 64'h0);
        // Limit reached mid-run, also for a key already held
        push_limit(2);
        push_request(CMD_INSERT, 64'h10);
        push_request(CMD_INSERT, 64'h18);
        push_request(CMD_INSERT, 64'h20);
        push_request(CMD_INSERT, 64'h10);
        push_request(CMD_CLEAR,  64'h3);
        // Hold off until every result is back
        push_drain();

        push_segment(8191, $urandom_range(SLOT_COUNT - 1));
        push_segment(25, $urandom_range(SLOT_COUNT - 1));
        push_segment(1, 4093);
        push_segment(300, $urandom_range(SLOT_COUNT - 1));

        // Phase two pacing: swapped
        push_pace(84, 37);
        push_segment(0, $urandom_range(SLOT_COUNT - 1));
        push_segment(4096, 4092);
        push_segment(120, $urandom_range(SLOT_COUNT - 1));
        push_segment(8, $urandom_range(SLOT_COUNT - 1));

        // Phase three: no idling; pile keys on the last slot so probes wrap
        push_pace(0, 0);
        push_limit(8191);
        push_request(CMD_CLEAR, 64'h0);
        push_request(CMD_INSERT, 64'h7_FFF8);
        push_request(CMD_INSERT, 64'h7_FFF9);
        push_request(CMD_INSERT, 64'h7_FFFA);
        push_request(CMD_INSERT, 64'h8);
        push_request(CMD_INSERT, 64'h7_FFFA);
        push_request(CMD_INSERT, 64'h8);
        push_request(CMD_INSERT, 64'h0);
        push_limit(4096);
        push_request(CMD_INSERT, 64'hBEEF_0000_0000_0001);
        push_limit(5);
        push_request(CMD_INSERT, 64'hBEEF_0000_0000_0002);
        push_request(CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);

        push_segment(1875, $urandom_range(SLOT_COUNT - 1));
        push_segment(4095, $urandom_range(SLOT_COUNT - 1));
        push_segment(60, 4094);
        push_segment(2, $urandom_range(SLOT_COUNT - 1));

        // Release reset
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for the plan to run out and all results to come back
        while (request_plan.size() != 0 || s_valid || outcome_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/lphs_pkg.sv
hw/rtl/lphs_dp.sv
hw/rtl/lphs_ctrl.sv
hw/rtl/linear_probe_hash_set_top.sv
bench/tb_top.sv
